/* src/chacha_pkg.sv */
// chacha_pkg: shared types, constants and the quarter-round helper
// for the chacha20 block generator; no dependencies
package chacha_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam int NUM_WORDS = 16;
  localparam int INDEX_W = 4;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef logic [31:0] word_t;

  localparam word_t SIGMA_0 = 32'h61707865;
  localparam word_t SIGMA_1 = 32'h3320646e;
  localparam word_t SIGMA_2 = 32'h79622d32;
  localparam word_t SIGMA_3 = 32'h6b206574;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_KEY_01   = 3'd0;
  localparam logic [2:0] REG_KEY_23   = 3'd1;
  localparam logic [2:0] REG_KEY_45   = 3'd2;
  localparam logic [2:0] REG_KEY_67   = 3'd3;
  localparam logic [2:0] REG_NONCE_01 = 3'd4;
  localparam logic [2:0] REG_NONCE_2  = 3'd5;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quarter_t;

  typedef struct packed {
    logic               load;
    logic               round_en;
    logic               diag;
    logic               second_half;
    logic               final_add;
    logic [INDEX_W-1:0] word_sel;
  } dp_cmd_t;

  // one half of a quarter round: rotations 16/12, or 8/7 for the second half
  function automatic quarter_t quarter_half(quarter_t q, logic second);
    quarter_t r;
    word_t    d_x;
    word_t    b_x;
    r   = q;
    r.a = q.a + q.b;
    d_x = q.d ^ r.a;
    r.d = second ? {d_x[23:0], d_x[31:24]} : {d_x[15:0], d_x[31:16]};
    r.c = q.c + r.d;
    b_x = q.b ^ r.c;
    r.b = second ? {b_x[24:0], b_x[31:25]} : {b_x[19:0], b_x[31:20]};
    return r;
  endfunction

endpackage

/* src/chacha_cfg.sv */
// chacha_cfg: apb register file holding the key and nonce words
// depends on chacha_pkg
module chacha_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [chacha_pkg::ADDR_W-1:0]       paddr,
  input  logic [chacha_pkg::DATA_W-1:0]       pwdata,
  output logic [chacha_pkg::DATA_W-1:0]       prdata,
  output logic                                pready,
  output chacha_pkg::word_t [7:0]             key,
  output chacha_pkg::word_t [2:0]             nonce
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[chacha_pkg::ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      key   <= '0;
      nonce <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        chacha_pkg::REG_KEY_01: begin
          key[0] <= pwdata[31:0];
          key[1] <= pwdata[63:32];
        end
        chacha_pkg::REG_KEY_23: begin
          key[2] <= pwdata[31:0];
          key[3] <= pwdata[63:32];
        end
        chacha_pkg::REG_KEY_45: begin
          key[4] <= pwdata[31:0];
          key[5] <= pwdata[63:32];
        end
        chacha_pkg::REG_KEY_67: begin
          key[6] <= pwdata[31:0];
          key[7] <= pwdata[63:32];
        end
        chacha_pkg::REG_NONCE_01: begin
          nonce[0] <= pwdata[31:0];
          nonce[1] <= pwdata[63:32];
        end
        chacha_pkg::REG_NONCE_2: begin
          nonce[2] <= pwdata[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      chacha_pkg::REG_KEY_01:   prdata = {key[1], key[0]};
      chacha_pkg::REG_KEY_23:   prdata = {key[3], key[2]};
      chacha_pkg::REG_KEY_45:   prdata = {key[5], key[4]};
      chacha_pkg::REG_KEY_67:   prdata = {key[7], key[6]};
      chacha_pkg::REG_NONCE_01: prdata = {nonce[1], nonce[0]};
      chacha_pkg::REG_NONCE_2:  prdata = {32'h0, nonce[2]};
      default:                  prdata = '0;
    endcase
  end

endmodule

/* src/chacha_datapath.sv */
// chacha_datapath: 16-word working state, half-quarter-round logic applied
// to all four quarters at once, final add and word select; depends on chacha_pkg
module chacha_datapath (
  input  logic                    clk,
  input  chacha_pkg::dp_cmd_t     cmd,
  input  chacha_pkg::word_t       block_counter,
  input  chacha_pkg::word_t [7:0] key,
  input  chacha_pkg::word_t [2:0] nonce,
  output chacha_pkg::word_t       keystream_word
);

  chacha_pkg::word_t work [chacha_pkg::NUM_WORDS];
  chacha_pkg::word_t work_round [chacha_pkg::NUM_WORDS];
  chacha_pkg::word_t init [chacha_pkg::NUM_WORDS];
  chacha_pkg::word_t counter_word;

  always_comb begin
    init[0]  = chacha_pkg::SIGMA_0;
    init[1]  = chacha_pkg::SIGMA_1;
    init[2]  = chacha_pkg::SIGMA_2;
    init[3]  = chacha_pkg::SIGMA_3;
    for (int k = 0; k < 8; k++) begin
      init[4 + k] = key[k];
    end
    init[12] = counter_word;
    init[13] = nonce[0];
    init[14] = nonce[1];
    init[15] = nonce[2];
  end

  // column step uses (j, 4+j, 8+j, 12+j), diagonal step rotates rows 1..3
  always_comb begin
    chacha_pkg::quarter_t                 q_in;
    chacha_pkg::quarter_t                 q_out;
    logic [chacha_pkg::INDEX_W-1:0]       bi;
    logic [chacha_pkg::INDEX_W-1:0]       ci;
    logic [chacha_pkg::INDEX_W-1:0]       di;
    q_in  = '0;
    q_out = '0;
    bi    = '0;
    ci    = '0;
    di    = '0;
    for (int m = 0; m < chacha_pkg::NUM_WORDS; m++) begin
      work_round[m] = work[m];
    end
    for (int j = 0; j < 4; j++) begin
      bi = chacha_pkg::INDEX_W'(cmd.diag ? 4 + ((j + 1) % 4) : 4 + j);
      ci = chacha_pkg::INDEX_W'(cmd.diag ? 8 + ((j + 2) % 4) : 8 + j);
      di = chacha_pkg::INDEX_W'(cmd.diag ? 12 + ((j + 3) % 4) : 12 + j);
      q_in.a = work[j];
      q_in.b = work[bi];
      q_in.c = work[ci];
      q_in.d = work[di];
      q_out = chacha_pkg::quarter_half(q_in, cmd.second_half);
      work_round[j]  = q_out.a;
      work_round[bi] = q_out.b;
      work_round[ci] = q_out.c;
      work_round[di] = q_out.d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      counter_word <= block_counter;
      for (int m = 0; m < chacha_pkg::NUM_WORDS; m++) begin
        work[m] <= (m == 12) ? block_counter : init[m];
      end
    end else if (cmd.round_en) begin
      for (int m = 0; m < chacha_pkg::NUM_WORDS; m++) begin
        work[m] <= work_round[m];
      end
    end else if (cmd.final_add) begin
      for (int m = 0; m < chacha_pkg::NUM_WORDS; m++) begin
        work[m] <= work[m] + init[m];
      end
    end
  end

  assign keystream_word = work[cmd.word_sel];

endmodule

/* src/chacha_ctrl.sv */
// chacha_ctrl: sequencer for load, round steps, final add and word output
// depends on chacha_pkg
module chacha_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [chacha_pkg::INDEX_W-1:0]     word_index,
  output logic                               last_word,
  output chacha_pkg::dp_cmd_t                cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  localparam logic [chacha_pkg::ROUND_W-1:0] LAST_ROUND =
    chacha_pkg::ROUND_W'(chacha_pkg::DOUBLE_ROUNDS - 1);
  localparam logic [chacha_pkg::INDEX_W-1:0] LAST_INDEX =
    chacha_pkg::INDEX_W'(chacha_pkg::NUM_WORDS - 1);

  logic [1:0]                         state;
  logic [1:0]                         state_next;
  logic [1:0]                         phase;
  logic [chacha_pkg::ROUND_W-1:0]     round;
  logic [chacha_pkg::INDEX_W-1:0]     word_idx;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ROUND;
      ST_ROUND: if (phase == 2'd3 && round == LAST_ROUND) state_next = ST_ADD;
      ST_ADD:   state_next = ST_OUT;
      ST_OUT:   if (!out_stall && word_idx == LAST_INDEX) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= 2'd0;
      round    <= '0;
      word_idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          phase    <= 2'd0;
          round    <= '0;
          word_idx <= '0;
        end
        ST_ROUND: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            round <= round + 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            word_idx <= word_idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall   = (state != ST_IDLE);
  assign out_valid  = (state == ST_OUT);
  assign word_index = word_idx;
  assign last_word  = (word_idx == LAST_INDEX);

  always_comb begin
    cmd             = '0;
    cmd.load        = (state == ST_IDLE) && in_valid;
    cmd.round_en    = (state == ST_ROUND);
    cmd.diag        = phase[1];
    cmd.second_half = phase[0];
    cmd.final_add   = (state == ST_ADD);
    cmd.word_sel    = word_idx;
  end

endmodule

/* src/chacha20_block_generator_top.sv */
// chacha20_block_generator_top: chacha20 block function with apb key/nonce setup
// depends on chacha_pkg, chacha_cfg, chacha_ctrl, chacha_datapath
//
// Usage:
//   Program the key and nonce over the apb port while the block is idle
//   (64-bit registers at byte addresses 0, 8, 16, 24, 32, 40; pready always high).
//   Each input transfer carries a 32-bit block counter (in_valid / in_stall).
//   The block answers with 16 output transfers (out_valid / out_stall), one
//   keystream word each, word_index 0..15, last_word set on the sixteenth.
//   Sequence: after the input transfer, the block runs 10 double rounds, each
//   as column first half, column second half, diagonal first half and diagonal
//   second half, every step running half a quarter round on all four quarters;
//   the final add follows. Words then leave at one per cycle while out_stall
//   is low; the next input transfer is taken once the last word is out.
//   One block is in flight at a time: in_stall is high from acceptance until
//   the last word has been transferred.
//   When the receiver stalls, the current word and its index hold steady.
//   Synchronous reset clears the controller and sets key and nonce to zero.
module chacha20_block_generator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [31:0]                         block_counter,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [31:0]                         keystream_word,
  output logic [chacha_pkg::INDEX_W-1:0]      word_index,
  output logic                                last_word,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [chacha_pkg::ADDR_W-1:0]       paddr,
  input  logic [chacha_pkg::DATA_W-1:0]       pwdata,
  output logic [chacha_pkg::DATA_W-1:0]       prdata,
  output logic                                pready
);

  chacha_pkg::word_t [7:0] key;
  chacha_pkg::word_t [2:0] nonce;
  chacha_pkg::dp_cmd_t     cmd;

  chacha_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key),
    .nonce   (nonce)
  );

  chacha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .last_word  (last_word),
    .cmd        (cmd)
  );

  chacha_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .block_counter  (block_counter),
    .key            (key),
    .nonce          (nonce),
    .keystream_word (keystream_word)
  );

endmodule

/* sim/tb_chacha20_block_generator_top.sv */
`timescale 1ns / 100ps
// tb_chacha20_block_generator_top: self-checking testbench for the chacha20 block generator
// predicts the 16 keystream words of each block counter transfer and checks every output
// depends on chacha_pkg and chacha20_block_generator_top
module tb_chacha20_block_generator_top;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 80;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 78;

  localparam logic [2:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_7 = 3'd7;

  typedef logic [15:0][31:0] block_t;

  typedef struct {
    chacha_pkg::word_t                  word;
    logic [chacha_pkg::INDEX_W-1:0]     index;
    logic                               last;
  } ks_word_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [31:0]                        block_counter = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [31:0]                        keystream_word;
  logic [chacha_pkg::INDEX_W-1:0]     word_index;
  logic                               last_word;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [chacha_pkg::ADDR_W-1:0]      paddr = '0;
  logic [chacha_pkg::DATA_W-1:0]      pwdata = '0;
  logic [chacha_pkg::DATA_W-1:0]      prdata;
  logic                               pready;

  chacha_pkg::word_t key_copy[8];
  chacha_pkg::word_t nonce_copy[3];
  chacha_pkg::word_t counter_q[$];
  ks_word_t          expected_words[$];

  int       errors = 0;
  int       cycle_count = 0;
  int       in_gap = 0;
  int       out_wait = 0;
  int       hold_left = 0;
  logic     hold_armed = 1'b0;
  logic     hold_done = 1'b0;
  logic     idle_on = 1'b1;
  logic     offering;

  chacha20_block_generator_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .block_counter  (block_counter),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .keystream_word (keystream_word),
    .word_index     (word_index),
    .last_word      (last_word),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic chacha_pkg::word_t rotl(chacha_pkg::word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic block_t quarter_round(block_t s, int a, int b, int c, int d);
    s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 7);
    return s;
  endfunction

  function automatic void chacha_block_predict(chacha_pkg::word_t ctr);
    block_t   init_st;
    block_t   work;
    ks_word_t w;
    init_st[0] = chacha_pkg::SIGMA_0;
    init_st[1] = chacha_pkg::SIGMA_1;
    init_st[2] = chacha_pkg::SIGMA_2;
    init_st[3] = chacha_pkg::SIGMA_3;
    for (int i = 0; i < 8; i++) init_st[4 + i] = key_copy[i];
    init_st[12] = ctr;
    for (int i = 0; i < 3; i++) init_st[13 + i] = nonce_copy[i];
    work = init_st;
    for (int r = 0; r < chacha_pkg::DOUBLE_ROUNDS; r++) begin
      work = quarter_round(work, 0, 4, 8, 12);
      work = quarter_round(work, 1, 5, 9, 13);
      work = quarter_round(work, 2, 6, 10, 14);
      work = quarter_round(work, 3, 7, 11, 15);
      work = quarter_round(work, 0, 5, 10, 15);
      work = quarter_round(work, 1, 6, 11, 12);
      work = quarter_round(work, 2, 7, 8, 13);
      work = quarter_round(work, 3, 4, 9, 14);
    end
    for (int i = 0; i < chacha_pkg::NUM_WORDS; i++) begin
      w.word  = work[i] + init_st[i];
      w.index = chacha_pkg::INDEX_W'(i);
      w.last  = (i == chacha_pkg::NUM_WORDS - 1);
      expected_words.push_back(w);
    end
  endfunction

  function automatic void update_key_nonce(logic [2:0] idx, logic [63:0] val);
    case (idx)
      chacha_pkg::REG_KEY_01: begin
        key_copy[0] = val[31:0]; key_copy[1] = val[63:32];
      end
      chacha_pkg::REG_KEY_23: begin
        key_copy[2] = val[31:0]; key_copy[3] = val[63:32];
      end
      chacha_pkg::REG_KEY_45: begin
        key_copy[4] = val[31:0]; key_copy[5] = val[63:32];
      end
      chacha_pkg::REG_KEY_67: begin
        key_copy[6] = val[31:0]; key_copy[7] = val[63:32];
      end
      chacha_pkg::REG_NONCE_01: begin
        nonce_copy[0] = val[31:0]; nonce_copy[1] = val[63:32];
      end
      chacha_pkg::REG_NONCE_2: begin
        nonce_copy[2] = val[31:0];
      end
      default: begin
      end
    endcase
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    update_key_nonce(idx, val);
  endtask

  task automatic wait_drained();
    while (counter_q.size() > 0 || in_valid || expected_words.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] random_reg_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic chacha_pkg::word_t random_counter();
    case ($urandom_range(0, 3))
      0: return chacha_pkg::word_t'($urandom_range(0, 15));
      1: return 32'hffff_fff0 + chacha_pkg::word_t'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // stimulus: directed settings first, then random key/nonce phases
  initial begin
    for (int i = 0; i < 8; i++) key_copy[i] = '0;
    for (int i = 0; i < 3; i++) nonce_copy[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: all-zero key and nonce
    counter_q.push_back(32'h0000_0000);
    counter_q.push_back(32'h0000_0001);
    counter_q.push_back(32'hffff_ffff);
    counter_q.push_back(32'h8000_0000);
    counter_q.push_back(32'h7fff_ffff);
    counter_q.push_back(32'haaaa_aaaa);
    counter_q.push_back(32'h5555_5555);
    wait_drained();

    // well-known test key 00..1f with nonce 00000009 0000004a 00000000
    apb_write(chacha_pkg::REG_KEY_01, 64'h0706_0504_0302_0100);
    apb_write(chacha_pkg::REG_KEY_23, 64'h0f0e_0d0c_0b0a_0908);
    apb_write(chacha_pkg::REG_KEY_45, 64'h1716_1514_1312_1110);
    apb_write(chacha_pkg::REG_KEY_67, 64'h1f1e_1d1c_1b1a_1918);
    apb_write(chacha_pkg::REG_NONCE_01, 64'h4a00_0000_0900_0000);
    apb_write(chacha_pkg::REG_NONCE_2, 64'h0000_0000_0000_0000);
    counter_q.push_back(32'h0000_0001);
    counter_q.push_back(32'h0000_0000);
    wait_drained();

    // all-ones key and nonce, stray upper bits on the 32-bit register, unmapped writes
    apb_write(chacha_pkg::REG_KEY_01, '1);
    apb_write(chacha_pkg::REG_KEY_23, '1);
    apb_write(chacha_pkg::REG_KEY_45, '1);
    apb_write(chacha_pkg::REG_KEY_67, '1);
    apb_write(chacha_pkg::REG_NONCE_01, '1);
    apb_write(chacha_pkg::REG_NONCE_2, 64'hdead_beef_ffff_ffff);
    apb_write(REG_UNMAPPED_6, {$urandom, $urandom});
    apb_write(REG_UNMAPPED_7, 64'h0);
    counter_q.push_back(32'h0000_0000);
    counter_q.push_back(32'hffff_ffff);
    counter_q.push_back(32'h1234_5678);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      apb_write(chacha_pkg::REG_KEY_01, random_reg_value());
      apb_write(chacha_pkg::REG_KEY_23, random_reg_value());
      apb_write(chacha_pkg::REG_KEY_45, random_reg_value());
      apb_write(chacha_pkg::REG_KEY_67, random_reg_value());
      apb_write(chacha_pkg::REG_NONCE_01, random_reg_value());
      apb_write(chacha_pkg::REG_NONCE_2, random_reg_value());
      if ($urandom_range(0, 1))
        apb_write($urandom_range(0, 1) ? REG_UNMAPPED_6 : REG_UNMAPPED_7, random_reg_value());
      idle_on    = (p != 2);
      hold_armed = (p == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) counter_q.push_back(random_counter());
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("chacha20_block_generator_top regression: pass");
    else
      $display("chacha20_block_generator_top regression: fail");
    $finish;
  end

  // block counter driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        chacha_block_predict(block_counter);
        offering = 1'b0;
        in_gap = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (!offering) begin
        if (in_gap > 0)
          in_gap = in_gap - 1;
        else if (counter_q.size() > 0) begin
          block_counter <= counter_q.pop_front();
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // keystream monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected transfer: word %h index %0d last %b",
                   $time, keystream_word, word_index, last_word);
          errors++;
        end else begin
          if (keystream_word !== expected_words[0].word) begin
            $display("%0t keystream_word expected %h got %h",
                     $time, expected_words[0].word, keystream_word);
            errors++;
          end
          if (word_index !== expected_words[0].index) begin
            $display("%0t word_index expected %0d got %0d",
                     $time, expected_words[0].index, word_index);
            errors++;
          end
          if (last_word !== expected_words[0].last) begin
            $display("%0t last_word expected %b got %b",
                     $time, expected_words[0].last, last_word);
            errors++;
          end
          void'(expected_words.pop_front());
        end
        out_wait = idle_on ? $urandom_range(0, 5) : 0;
      end else if (out_wait > 0)
        out_wait = out_wait - 1;
      else if (!out_valid && idle_on && $urandom_range(0, 15) == 0)
        out_wait = $urandom_range(1, 5);
      out_stall <= (out_wait > 0) || (hold_left > 0);
    end
  end

  // one long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_armed && !hold_done && out_valid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("chacha20_block_generator_top regression: fail");
      $finish;
    end
  end

endmodule

/* filelist.f */
src/chacha_pkg.sv
src/chacha_cfg.sv
src/chacha_datapath.sv
src/chacha_ctrl.sv
src/chacha20_block_generator_top.sv
sim/tb_chacha20_block_generator_top.sv
